### rtl/aer_pkg.sv
// ----------------------------------------------------------------------------
// aer_pkg
// Shared types and constants for the arithmetic encoder renormaliser.
// ----------------------------------------------------------------------------
package aer_pkg;

  localparam int VALUE_WIDTH_DEF   = 32;
  localparam int PENDING_WIDTH_DEF = 16;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_RENORM = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] low_in;
    logic [31:0] range_in;
  } in_item_t;

  typedef struct packed {
    logic        has_run;
    logic        run_bit;
    logic [15:0] pending_count;
    logic        pending_saturated;
    logic [31:0] low_out;
    logic [31:0] range_out;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic renorm_step;
    logic finish_step;
    logic close;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic renorm_done;
    logic finish_end;
  } dp_status_t;

endpackage

### rtl/arith_encoder_renormalizer.sv
// ----------------------------------------------------------------------------
// arith_encoder_renormalizer
// Encoder-side renormalisation with pending bits for a binary arithmetic coder.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data): one operation with a narrowed
// interval. Start clears the pending count, renormalize doubles the interval
// while range is at most a quarter scale, finish runs the termination passes.
// Output channel (out_valid/out_stall/out_data): one transfer per decided bit
// with its pending run length, then a closing transfer (last set) with the
// normalised low and range.
// One item is worked at a time. The interval loop does one doubling per cycle
// while the result register is free. A single result register holds each
// transfer; while out_stall is high the loop waits and in_stall stays high
// until the closing transfer is loaded.
// Reset (rst, synchronous): pending count zero, interval (0, half scale),
// no result pending.
// ----------------------------------------------------------------------------
module arith_encoder_renormalizer #(
  parameter int VALUE_WIDTH   = aer_pkg::VALUE_WIDTH_DEF,
  parameter int PENDING_WIDTH = aer_pkg::PENDING_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  aer_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output aer_pkg::out_item_t out_data
);
  import aer_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  aer_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (in_data.operation),
    .status    (status),
    .cmd       (cmd)
  );

  aer_datapath #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .PENDING_WIDTH (PENDING_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/aer_datapath.sv
// ----------------------------------------------------------------------------
// aer_datapath
// Interval registers, pending count, pass counter and result register.
// ----------------------------------------------------------------------------
module aer_datapath #(
  parameter int VALUE_WIDTH   = aer_pkg::VALUE_WIDTH_DEF,
  parameter int PENDING_WIDTH = aer_pkg::PENDING_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  aer_pkg::in_item_t   in_data,
  input  aer_pkg::dp_cmd_t    cmd,
  output aer_pkg::dp_status_t status,
  output logic                out_valid,
  input  logic                out_stall,
  output aer_pkg::out_item_t  out_data
);
  import aer_pkg::*;

  localparam int PCW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam logic [VALUE_WIDTH-1:0] HALF    = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [VALUE_WIDTH-1:0] QUARTER = HALF >> 1;
  localparam logic [PENDING_WIDTH-1:0] PMAX  = '1;
  localparam logic [PCW-1:0] LAST_PASS       = PCW'(VALUE_WIDTH - 1);

  logic [VALUE_WIDTH-1:0]   low;
  logic [VALUE_WIDTH-1:0]   range;
  logic [PENDING_WIDTH-1:0] pending;
  logic [PCW-1:0]           pass;

  logic [VALUE_WIDTH+31:0]   low_in_ext;
  logic [VALUE_WIDTH+31:0]   range_in_ext;
  logic [VALUE_WIDTH+31:0]   low_out_ext;
  logic [VALUE_WIDTH+31:0]   range_out_ext;
  logic [PENDING_WIDTH+15:0] pend_out_ext;

  logic [VALUE_WIDTH:0]   sum_full;
  logic [VALUE_WIDTH:0]   sum_half;
  logic [VALUE_WIDTH-1:0] rn_low;
  logic                   rn_emit;
  logic                   rn_bit;
  logic [VALUE_WIDTH-1:0] fn_low;
  logic [VALUE_WIDTH-1:0] fn_range;
  logic                   fn_bit;
  logic                   emit;
  logic                   emit_bit;

  assign low_in_ext    = {{VALUE_WIDTH{1'b0}}, in_data.low_in};
  assign range_in_ext  = {{VALUE_WIDTH{1'b0}}, in_data.range_in};
  assign low_out_ext   = {32'b0, low};
  assign range_out_ext = {32'b0, range};
  assign pend_out_ext  = {16'b0, pending};

  assign sum_full = {1'b0, low} + {1'b0, range};
  assign sum_half = {1'b0, low} + {1'b0, range >> 1};

  // one renormalising doubling
  always_comb begin
    rn_low  = low;
    rn_emit = 1'b0;
    rn_bit  = 1'b0;
    if (low >= HALF) begin
      rn_emit = 1'b1;
      rn_bit  = 1'b1;
      rn_low  = low - HALF;
    end else if (sum_full <= {1'b0, HALF}) begin
      rn_emit = 1'b1;
    end else begin
      rn_low = low - QUARTER;
    end
  end

  // one termination pass, before the doubling
  always_comb begin
    fn_low   = low;
    fn_range = range;
    fn_bit   = 1'b0;
    if (sum_half >= {1'b0, HALF}) begin
      fn_bit = 1'b1;
      if (low < HALF) begin
        fn_range = range - (HALF - low);
        fn_low   = '0;
      end else begin
        fn_low = low - HALF;
      end
    end else if (sum_full > {1'b0, HALF}) begin
      fn_range = HALF - low;
    end
  end

  assign emit     = (cmd.renorm_step && rn_emit) || cmd.finish_step;
  assign emit_bit = cmd.finish_step ? fn_bit : rn_bit;

  assign status.out_free    = !out_valid || !out_stall;
  assign status.renorm_done = (pass == LAST_PASS) || (range > QUARTER);
  assign status.finish_end  = (fn_range == HALF) || (pass == LAST_PASS);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      low     <= '0;
      range   <= HALF;
      pass    <= '0;
    end else if (cmd.load) begin
      pass <= '0;
      unique case (in_data.operation)
        OP_START: begin
          pending <= '0;
          low     <= '0;
          range   <= HALF;
        end
        OP_RENORM, OP_FINISH: begin
          low   <= low_in_ext[VALUE_WIDTH-1:0];
          range <= range_in_ext[VALUE_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end else if (cmd.renorm_step) begin
      low   <= rn_low << 1;
      range <= range << 1;
      pass  <= pass + 1'b1;
      if (rn_emit) begin
        pending <= '0;
      end else if (pending != PMAX) begin
        pending <= pending + 1'b1;
      end
    end else if (cmd.finish_step) begin
      pending <= '0;
      pass    <= pass + 1'b1;
      // once the range reaches half scale the interval is kept undoubled
      if (fn_range == HALF) begin
        low   <= fn_low;
        range <= fn_range;
      end else begin
        low   <= fn_low << 1;
        range <= fn_range << 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit || cmd.close) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.has_run           <= 1'b1;
      out_data.run_bit           <= emit_bit;
      out_data.pending_count     <= pend_out_ext[15:0];
      out_data.pending_saturated <= (pending == PMAX);
      out_data.low_out           <= '0;
      out_data.range_out         <= '0;
      out_data.last              <= 1'b0;
    end else if (cmd.close) begin
      out_data.has_run           <= 1'b0;
      out_data.run_bit           <= 1'b0;
      out_data.pending_count     <= '0;
      out_data.pending_saturated <= 1'b0;
      out_data.low_out           <= low_out_ext[31:0];
      out_data.range_out         <= range_out_ext[31:0];
      out_data.last              <= 1'b1;
    end
  end

endmodule

### rtl/aer_controller.sv
// ----------------------------------------------------------------------------
// aer_controller
// Sequencer: takes an item, steps the doubling loop for renormalize or finish, then closes it.
// ----------------------------------------------------------------------------
module aer_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          operation,
  input  aer_pkg::dp_status_t status,
  output aer_pkg::dp_cmd_t    cmd
);
  import aer_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_RENORM = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;
  localparam logic [1:0] S_CLOSE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (operation == OP_RENORM) begin
            state_next = S_RENORM;
          end else if (operation == OP_FINISH) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_CLOSE;
          end
        end
      end
      S_RENORM: begin
        if (status.out_free) begin
          if (status.renorm_done) begin
            state_next = S_CLOSE;
          end else begin
            cmd.renorm_step = 1'b1;
          end
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish_step = 1'b1;
          if (status.finish_end) begin
            state_next = S_CLOSE;
          end
        end
      end
      S_CLOSE: begin
        if (status.out_free) begin
          cmd.close  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the arithmetic encoder renormaliser against an in-bench predictor.
// A table of directed operations runs first: interval extremes, the unused
// opcode, zero and over-wide ranges, and runaway renormalize and finish.
// A short pending chain follows, building up a long run of pending bits.
// Then come random start/renormalize/finish sequences that narrow the held
// interval, mixed with unconstrained items. The sender works in bursts and
// the receiver stalls on its own pattern, with one long hold-off.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import aer_pkg::*;

  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam logic [31:0] HALF       = 32'h8000_0000;
  localparam logic [31:0] QUARTER    = 32'h4000_0000;
  localparam logic [15:0] PEND_MAX   = 16'hFFFF;
  localparam int          IDLE_LIMIT = 4000;
  localparam int          HOLD_OFF   = 500;
  localparam int          SAT_ITEMS  = 4;
  localparam int          RAND_ITEMS = 148;

  typedef logic [$bits(out_item_t)-1:0] out_bits_t;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] low;
    logic [31:0] rng;
    bit          typed;
    logic [31:0] close_low;
    logic [31:0] close_range;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;

  // predicted coder state
  logic [15:0] pend_count = '0;
  logic [31:0] interval_low = '0;
  logic [31:0] interval_range = HALF;

  out_item_t   coded_runs_q[$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  int          burst_left = 8;
  bit          hold_off_due = 1'b0;

  stim_row_t directed_rows[22] = '{
    '{OP_START,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, HALF},
    '{OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, HALF},
    '{OP_RENORM, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 32'hFFFF_FFFF, 32'h8000_0000},
    '{OP_RENORM, 32'h0000_0000, 32'h4000_0001, 1'b1, 32'h0000_0000, 32'h4000_0001},
    '{OP_UNUSED, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'h4000_0001},
    '{OP_RENORM, 32'h0000_0005, 32'hFFFF_FFFF, 1'b1, 32'h0000_0005, 32'hFFFF_FFFF},
    '{OP_RENORM, 32'h0000_0000, 32'h0000_0001, 1'b0, 32'h0, 32'h0},
    '{OP_RENORM, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 32'h0, 32'h0},
    '{OP_RENORM, 32'h7FFF_FFFF, 32'h0000_0002, 1'b0, 32'h0, 32'h0},
    '{OP_RENORM, 32'h3FFF_FFFF, 32'h4000_0000, 1'b0, 32'h0, 32'h0},
    '{OP_RENORM, 32'h7FFF_FFFF, 32'h0000_0002, 1'b0, 32'h0, 32'h0},
    '{OP_RENORM, 32'h8000_0000, 32'h4000_0000, 1'b0, 32'h0, 32'h0},
    '{OP_RENORM, 32'h1234_5678, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{OP_RENORM, 32'h8000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{OP_FINISH, 32'h0000_0000, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
    '{OP_FINISH, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
    '{OP_FINISH, 32'h4000_0000, 32'h4000_0000, 1'b0, 32'h0, 32'h0},
    '{OP_FINISH, 32'h1234_5678, 32'h0000_0001, 1'b0, 32'h0, 32'h0},
    '{OP_FINISH, 32'h1111_1111, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{OP_FINISH, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
    '{OP_FINISH, 32'h7FFF_FFFF, 32'h0000_0002, 1'b0, 32'h0, 32'h0},
    '{OP_START,  32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1, 32'h0000_0000, HALF}
  };

  arith_encoder_renormalizer dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic in_item_t mk_item(logic [1:0] op, logic [31:0] lo, logic [31:0] rg);
    in_item_t it;
    it.operation = op;
    it.low_in    = lo;
    it.range_in  = rg;
    return it;
  endfunction

  // decided bit plus the opposite bits owed to it; clears the pending count
  function automatic out_item_t take_run(logic b);
    out_item_t r;
    r = '0;
    r.has_run           = 1'b1;
    r.run_bit           = b;
    r.pending_count     = pend_count;
    r.pending_saturated = (pend_count == PEND_MAX);
    pend_count          = '0;
    return r;
  endfunction

  function automatic void renormalize_interval(input in_item_t it, ref out_item_t res[$]);
    logic [31:0] lo;
    logic [31:0] rg;
    out_item_t   cl;
    int          pass;
    lo = it.low_in;
    rg = it.range_in;
    cl = '0;
    case (it.operation)
      OP_START: begin
        pend_count     = '0;
        interval_low   = '0;
        interval_range = HALF;
      end
      OP_RENORM: begin
        for (pass = 0; pass < 31 && rg <= QUARTER; pass++) begin
          if (lo >= HALF) begin
            res.push_back(take_run(1'b1));
            lo = lo - HALF;
          end else if ({1'b0, lo} + {1'b0, rg} <= {1'b0, HALF}) begin
            res.push_back(take_run(1'b0));
          end else begin
            // straddles the midpoint: defer the bit
            if (pend_count != PEND_MAX) pend_count++;
            lo = lo - QUARTER;
          end
          lo = lo << 1;
          rg = rg << 1;
        end
        interval_low   = lo;
        interval_range = rg;
      end
      OP_FINISH: begin
        for (pass = 0; pass < 32; pass++) begin
          if ({1'b0, lo} + {1'b0, rg >> 1} >= {1'b0, HALF}) begin
            res.push_back(take_run(1'b1));
            if (lo < HALF) begin
              rg = rg - (HALF - lo);
              lo = '0;
            end else begin
              lo = lo - HALF;
            end
          end else begin
            res.push_back(take_run(1'b0));
            if ({1'b0, lo} + {1'b0, rg} > {1'b0, HALF}) rg = HALF - lo;
          end
          if (rg == HALF) break;
          lo = lo << 1;
          rg = rg << 1;
        end
        interval_low   = lo;
        interval_range = rg;
      end
      default: begin
      end
    endcase
    cl.low_out   = interval_low;
    cl.range_out = interval_range;
    cl.last      = 1'b1;
    res.push_back(cl);
  endfunction

  // a sub-interval of the one currently held, often much narrower
  function automatic in_item_t narrowed(logic [1:0] op);
    logic [31:0] span;
    logic [31:0] r;
    span = interval_range;
    if (span == 0 || span > HALF) span = HALF;
    r = span >> $urandom_range(0, 31);
    if (r == 0) r = 1;
    r = $urandom_range(1, r);
    return mk_item(op, interval_low + $urandom_range(0, span - r), r);
  endfunction

  function automatic in_item_t noise_item();
    logic [31:0] rg;
    case ($urandom_range(0, 2))
      0:       rg = $urandom();
      1:       rg = $urandom_range(1, HALF);
      default: rg = $urandom() >> $urandom_range(0, 31);
    endcase
    return mk_item(2'($urandom_range(0, 3)), $urandom(), rg);
  endfunction

  task automatic report_mismatch(string what, out_bits_t got, out_bits_t want);
    $display("ERROR %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // offer one item, wait for its transfer, then predict and maybe pause
  task automatic offer(input in_item_t it, input bit typed = 1'b0,
                       input out_item_t typed_close = '0);
    out_item_t res[$];
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    renormalize_interval(it, res);
    if (typed) coded_runs_q.push_back(typed_close);
    else foreach (res[i]) coded_runs_q.push_back(res[i]);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (coded_runs_q.size() == 0) begin
        report_mismatch("result with nothing expected", out_data, '0);
      end else begin
        want = coded_runs_q.pop_front();
        if (out_data.has_run !== want.has_run)
          report_mismatch("has_run", out_bits_t'(out_data.has_run),
                          out_bits_t'(want.has_run));
        if (out_data.run_bit !== want.run_bit)
          report_mismatch("run_bit", out_bits_t'(out_data.run_bit),
                          out_bits_t'(want.run_bit));
        if (out_data.pending_count !== want.pending_count)
          report_mismatch("pending_count", out_bits_t'(out_data.pending_count),
                          out_bits_t'(want.pending_count));
        if (out_data.pending_saturated !== want.pending_saturated)
          report_mismatch("pending_saturated", out_bits_t'(out_data.pending_saturated),
                          out_bits_t'(want.pending_saturated));
        if (out_data.low_out !== want.low_out)
          report_mismatch("low_out", out_bits_t'(out_data.low_out),
                          out_bits_t'(want.low_out));
        if (out_data.range_out !== want.range_out)
          report_mismatch("range_out", out_bits_t'(out_data.range_out),
                          out_bits_t'(want.range_out));
        if (out_data.last !== want.last)
          report_mismatch("last", out_bits_t'(out_data.last), out_bits_t'(want.last));
      end
    end
  end

  // watchdog: cycles without any transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stall pattern
  initial begin
    int seg;
    int mode;
    int k;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
      end
      seg  = $urandom_range(20, 150);
      mode = $urandom_range(0, 3);
      for (k = 0; k < seg; k++) begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= 1'($urandom_range(0, 1));
          2:       out_stall <= ((k % 4) == 3);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // stimulus
  initial begin
    out_item_t cl;
    int        sent;
    int        n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      cl           = '0;
      cl.low_out   = directed_rows[i].close_low;
      cl.range_out = directed_rows[i].close_range;
      cl.last      = 1'b1;
      offer(mk_item(directed_rows[i].op, directed_rows[i].low, directed_rows[i].rng),
            directed_rows[i].typed, cl);
    end

    // each 7FFF_FFFF renormalize straddles the midpoint on every doubling: thirty pending bits per item
    offer(mk_item(OP_START, 32'h0, 32'h0));
    repeat (SAT_ITEMS) offer(mk_item(OP_RENORM, 32'h7FFF_FFFF, 32'h0000_0002));
    offer(mk_item(OP_RENORM, 32'h3FFF_FFFF, 32'h4000_0000));
    repeat (3) offer(mk_item(OP_RENORM, 32'h7FFF_FFFF, 32'h0000_0002));
    offer(mk_item(OP_FINISH, 32'h7FFF_FFFF, 32'h0000_0002));

    hold_off_due = 1'b1;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 1) == 0) begin
          offer(mk_item(OP_START, $urandom(), $urandom()));
          sent++;
        end
        n = $urandom_range(1, 8);
        repeat (n) begin
          offer(narrowed(OP_RENORM));
          sent++;
        end
        offer(narrowed(OP_FINISH));
        sent++;
      end else begin
        offer(noise_item());
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (coded_runs_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/aer_pkg.sv
rtl/aer_datapath.sv
rtl/aer_controller.sv
rtl/arith_encoder_renormalizer.sv
test/testbench.sv
